// ----- hw/rtl/ebss_pkg.sv -----
// Shared types, constants and table functions for the entropy split search block.
`timescale 1ns / 1ps

package ebss_pkg;

  localparam int DEF_MAX_SAMPLES = 256;
  localparam int DEF_NUM_CLASSES = 16;
  localparam int DEF_VALUE_BITS  = 32;

  localparam int IN_VALUE_W = 32;
  localparam int IN_CLASS_W = 4;
  localparam int OUT_THR_W  = 32;
  localparam int ENT_W      = 26;
  localparam logic [ENT_W-1:0] ENT_MAX = '1;

  // Values within this many LSBs of the first sample count as equal (about 0.0001).
  localparam int SAME_TOL = 6;

  typedef enum logic {
    OP_PREP,
    OP_PASS
  } rd_op_t;

  typedef struct packed {
    logic   ld;
    logic   clr;
    logic   rd_en;
    rd_op_t rd_op;
    logic   rd_first;
    logic   advance;
    logic   sweep_init;
    logic   sweep_en;
    logic   tot_en;
    logic   cmp;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic spread;
    logic mixed;
    logic nxt_found;
  } sts_t;

  // n*log2(n) in Q16.16; log2 is built by repeated squaring with 32 fraction bits.
  // Only evaluated at elaboration to fill a constant table.
  function automatic logic [63:0] nlog_q16(input int unsigned n);
    int unsigned k;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] lg;
    k    = 0;
    frac = '0;
    if (n < 2) begin
      return '0;
    end
    while ((n >> (k + 1)) != 0) begin
      k++;
    end
    m = (64'(n) << 31) >> k;
    for (int b = 31; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        m       = m >> 1;
        frac[b] = 1'b1;
      end
    end
    lg = (64'(k) << 32) | frac;
    return (lg * 64'(n) + 64'h8000) >> 16;
  endfunction

endpackage

// ----- hw/rtl/ebss_ctrl.sv -----
// Sequencer for loading, scanning, sweeping and scoring the sample column.
`timescale 1ns / 1ps

module ebss_ctrl #(
  parameter int MAX_SAMPLES = ebss_pkg::DEF_MAX_SAMPLES,
  parameter int NUM_CLASSES = ebss_pkg::DEF_NUM_CLASSES,
  localparam int AW    = $clog2(MAX_SAMPLES),
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int CLS_W = $clog2(NUM_CLASSES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ebss_pkg::sts_t     sts,
  input  logic [CNT_W-1:0]   cnt,
  output ebss_pkg::cmd_t     cmd,
  output logic [AW-1:0]      rd_addr,
  output logic [CLS_W-1:0]   cls_idx
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_CLR,
    S_PREP,
    S_PREP_END,
    S_CHK,
    S_PASS,
    S_PASS_END,
    S_PCHK,
    S_SWEEP,
    S_SWEEP_END,
    S_TOT,
    S_TERM,
    S_CMP,
    S_FIN,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] idx_r;
  logic [CLS_W-1:0] cls_r;
  logic             idx_last;
  logic             cls_last;

  assign idx_last  = (idx_r == CNT_W'(cnt - 1'b1));
  assign cls_last  = (cls_r == CLS_W'(NUM_CLASSES - 1));
  assign rd_addr   = idx_r[AW-1:0];
  assign cls_idx   = cls_r;
  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd       = '0;
    cmd.rd_op = ebss_pkg::OP_PREP;
    case (state_r)
      S_LOAD: cmd.ld = in_valid;
      S_CLR:  cmd.clr = 1'b1;
      S_PREP: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (idx_r == '0);
      end
      S_CHK:  cmd.advance = 1'b1;
      S_PASS: begin
        cmd.rd_en = 1'b1;
        cmd.rd_op = ebss_pkg::OP_PASS;
      end
      S_PCHK:  cmd.sweep_init = 1'b1;
      S_SWEEP: cmd.sweep_en = 1'b1;
      S_TOT:   cmd.tot_en = 1'b1;
      S_CMP: begin
        cmd.cmp     = 1'b1;
        cmd.advance = 1'b1;
      end
      S_FIN:   cmd.out_load = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      idx_r   <= '0;
      cls_r   <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_valid && in_last) begin
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          idx_r   <= '0;
          state_r <= (cnt < CNT_W'(2)) ? S_FIN : S_PREP;
        end
        S_PREP: begin
          if (idx_last) begin
            state_r <= S_PREP_END;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_PREP_END: state_r <= S_CHK;
        S_CHK: begin
          idx_r   <= '0;
          state_r <= (sts.spread && sts.mixed) ? S_PASS : S_FIN;
        end
        S_PASS: begin
          if (idx_last) begin
            state_r <= S_PASS_END;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_PASS_END: state_r <= S_PCHK;
        S_PCHK: begin
          cls_r   <= '0;
          state_r <= sts.nxt_found ? S_SWEEP : S_FIN;
        end
        S_SWEEP: begin
          if (cls_last) begin
            state_r <= S_SWEEP_END;
          end else begin
            cls_r <= cls_r + 1'b1;
          end
        end
        S_SWEEP_END: state_r <= S_TOT;
        S_TOT:       state_r <= S_TERM;
        S_TERM:      state_r <= S_CMP;
        S_CMP: begin
          idx_r   <= '0;
          state_r <= S_PASS;
        end
        S_FIN: state_r <= S_OUT;
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ebss_dpath.sv -----
// Sample memory, class histograms, entropy accumulation and best-split registers.
`timescale 1ns / 1ps

module ebss_dpath #(
  parameter int MAX_SAMPLES = ebss_pkg::DEF_MAX_SAMPLES,
  parameter int NUM_CLASSES = ebss_pkg::DEF_NUM_CLASSES,
  parameter int VALUE_BITS  = ebss_pkg::DEF_VALUE_BITS,
  localparam int AW    = $clog2(MAX_SAMPLES),
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int CLS_W = $clog2(NUM_CLASSES)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ebss_pkg::cmd_t                    cmd,
  input  logic [AW-1:0]                     rd_addr,
  input  logic [CLS_W-1:0]                  cls_idx,
  input  logic [ebss_pkg::IN_VALUE_W-1:0]   in_value,
  input  logic [ebss_pkg::IN_CLASS_W-1:0]   in_class,
  output ebss_pkg::sts_t                    sts,
  output logic [CNT_W-1:0]                  cnt,
  output logic [ebss_pkg::OUT_THR_W-1:0]    out_thr,
  output logic [ebss_pkg::ENT_W-1:0]        out_ent,
  output logic                              out_ns
);

  localparam int ENT_W  = ebss_pkg::ENT_W;
  localparam int NLOG_W = $clog2(ebss_pkg::nlog_q16(MAX_SAMPLES) + 64'd1);
  localparam int SUM_W  = NLOG_W + CLS_W;
  localparam int CMP_W  = (NLOG_W + 1 > ENT_W) ? NLOG_W + 1 : ENT_W;
  localparam int ENT_WD = VALUE_BITS + CLS_W;

  typedef logic [NLOG_W-1:0] nlog_tab_t [MAX_SAMPLES + 1];

  function automatic nlog_tab_t build_tab();
    nlog_tab_t t;
    for (int i = 0; i <= MAX_SAMPLES; i++) begin
      t[i] = NLOG_W'(ebss_pkg::nlog_q16(i));
    end
    return t;
  endfunction

  localparam nlog_tab_t NLOG_TAB = build_tab();

  logic [ENT_WD-1:0]            mem [MAX_SAMPLES];
  logic [ENT_WD-1:0]            rd_data_r;
  logic                         rd_vld_r;
  logic                         rd_first_r;
  ebss_pkg::rd_op_t             rd_op_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             j_r;
  logic [CNT_W-1:0]             lh_r [NUM_CLASSES];
  logic [CNT_W-1:0]             rh_r [NUM_CLASSES];
  logic signed [VALUE_BITS-1:0] v0_r;
  logic signed [VALUE_BITS-1:0] tcur_r;
  logic signed [VALUE_BITS-1:0] nxt_r;
  logic signed [VALUE_BITS-1:0] best_thr_r;
  logic signed [VALUE_BITS-1:0] best_nxt_r;
  logic [CLS_W-1:0]             c0_r;
  logic                         spread_r;
  logic                         mixed_r;
  logic                         nxt_found_r;
  logic                         have_r;
  logic [NLOG_W-1:0]            rom_a_r;
  logic [NLOG_W-1:0]            rom_b_r;
  logic                         rom_sweep_r;
  logic                         rom_tot_r;
  logic [SUM_W-1:0]             sum_l_r;
  logic [SUM_W-1:0]             sum_r_r;
  logic [NLOG_W-1:0]            term_l_r;
  logic [NLOG_W-1:0]            term_r_r;
  logic [ENT_W-1:0]             best_ent_r;
  logic [ebss_pkg::OUT_THR_W-1:0] out_thr_r;
  logic [ENT_W-1:0]             out_ent_r;
  logic                         out_ns_r;

  logic [VALUE_BITS-1:0]        ld_val;
  logic [6:0]                   cls_tmp;
  logic [CLS_W-1:0]             ld_cls;
  logic signed [VALUE_BITS-1:0] d_val;
  logic [CLS_W-1:0]             d_cls;
  logic [CLS_W-1:0]             hsel;
  logic signed [VALUE_BITS:0]   diff;
  logic                         far;
  logic                         prep_do;
  logic                         pass_do;
  logic                         move;
  logic                         nxt_take;
  logic [CNT_W-1:0]             rom_a_addr;
  logic [CNT_W-1:0]             rom_b_addr;
  logic [NLOG_W-1:0]            term_l_nxt;
  logic [NLOG_W-1:0]            term_r_nxt;
  logic [CMP_W-1:0]             tot;
  logic [ENT_W-1:0]             ent_sat;
  logic                         better;
  logic signed [VALUE_BITS:0]   msum;
  logic [VALUE_BITS-1:0]        mid;

  // Low VALUE_BITS of the input word; bits above the port width read as zero.
  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      ld_val[i] = (i < ebss_pkg::IN_VALUE_W) && in_value[i & (ebss_pkg::IN_VALUE_W - 1)];
    end
  end

  // Class label reduced modulo NUM_CLASSES by repeated subtraction.
  always_comb begin
    cls_tmp = 7'(in_class);
    for (int k = 0; k < 8; k++) begin
      if (cls_tmp >= 7'(NUM_CLASSES)) begin
        cls_tmp = cls_tmp - 7'(NUM_CLASSES);
      end
    end
    ld_cls = cls_tmp[CLS_W-1:0];
  end

  assign d_val    = rd_data_r[ENT_WD-1:CLS_W];
  assign d_cls    = rd_data_r[CLS_W-1:0];
  assign hsel     = cmd.sweep_en ? cls_idx : d_cls;
  assign diff     = {d_val[VALUE_BITS-1], d_val} - {v0_r[VALUE_BITS-1], v0_r};
  assign far      = (diff > $signed((VALUE_BITS + 1)'(ebss_pkg::SAME_TOL))) ||
                    (diff < -$signed((VALUE_BITS + 1)'(ebss_pkg::SAME_TOL)));
  assign prep_do  = rd_vld_r && (rd_op_r == ebss_pkg::OP_PREP);
  assign pass_do  = rd_vld_r && (rd_op_r == ebss_pkg::OP_PASS);
  assign move     = pass_do && (d_val == tcur_r);
  assign nxt_take = (prep_do || (pass_do && (d_val > tcur_r))) &&
                    (!nxt_found_r || (d_val < nxt_r));

  assign rom_a_addr = cmd.tot_en ? j_r : lh_r[hsel];
  assign rom_b_addr = cmd.tot_en ? CNT_W'(cnt_r - j_r) : rh_r[hsel];

  // A side's term never goes below zero.
  assign term_l_nxt = (SUM_W'(rom_a_r) > sum_l_r) ? NLOG_W'(SUM_W'(rom_a_r) - sum_l_r) : '0;
  assign term_r_nxt = (SUM_W'(rom_b_r) > sum_r_r) ? NLOG_W'(SUM_W'(rom_b_r) - sum_r_r) : '0;

  assign tot     = CMP_W'(term_l_r) + CMP_W'(term_r_r);
  assign ent_sat = (tot > CMP_W'(ebss_pkg::ENT_MAX)) ? ebss_pkg::ENT_MAX : ENT_W'(tot);
  assign better  = !have_r || (ent_sat < best_ent_r);

  // Floor of the midpoint: arithmetic shift of the one-bit-wider sum.
  assign msum = {best_thr_r[VALUE_BITS-1], best_thr_r} + {best_nxt_r[VALUE_BITS-1], best_nxt_r};
  assign mid  = msum[VALUE_BITS:1];

  always_ff @(posedge clk) begin
    if (cmd.ld && (cnt_r < CNT_W'(MAX_SAMPLES))) begin
      mem[cnt_r[AW-1:0]] <= {ld_val, ld_cls};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      rd_first_r  <= 1'b0;
      rd_op_r     <= ebss_pkg::OP_PREP;
      cnt_r       <= '0;
      j_r         <= '0;
      spread_r    <= 1'b0;
      mixed_r     <= 1'b0;
      nxt_found_r <= 1'b0;
      have_r      <= 1'b0;
      rom_sweep_r <= 1'b0;
      rom_tot_r   <= 1'b0;
      best_ent_r  <= ebss_pkg::ENT_MAX;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        lh_r[c] <= '0;
        rh_r[c] <= '0;
      end
    end else begin
      rd_vld_r    <= cmd.rd_en;
      rd_first_r  <= cmd.rd_first;
      rd_op_r     <= cmd.rd_op;
      rom_sweep_r <= cmd.sweep_en;
      rom_tot_r   <= cmd.tot_en;

      if (cmd.ld && (cnt_r < CNT_W'(MAX_SAMPLES))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        cnt_r <= '0;
      end

      if (cmd.clr) begin
        j_r         <= '0;
        spread_r    <= 1'b0;
        mixed_r     <= 1'b0;
        nxt_found_r <= 1'b0;
        have_r      <= 1'b0;
        best_ent_r  <= ebss_pkg::ENT_MAX;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          lh_r[c] <= '0;
          rh_r[c] <= '0;
        end
      end else begin
        if (prep_do) begin
          rh_r[hsel] <= rh_r[hsel] + 1'b1;
          if (!rd_first_r) begin
            if (far) begin
              spread_r <= 1'b1;
            end
            if (d_cls != c0_r) begin
              mixed_r <= 1'b1;
            end
          end
        end
        if (move) begin
          lh_r[hsel] <= lh_r[hsel] + 1'b1;
          rh_r[hsel] <= rh_r[hsel] - 1'b1;
          j_r        <= j_r + 1'b1;
        end
        if (cmd.advance) begin
          nxt_found_r <= 1'b0;
        end else if (nxt_take) begin
          nxt_found_r <= 1'b1;
        end
        if (cmd.cmp && better) begin
          have_r     <= 1'b1;
          best_ent_r <= ent_sat;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (prep_do && rd_first_r) begin
      v0_r <= d_val;
      c0_r <= d_cls;
    end
    if (nxt_take && !cmd.advance) begin
      nxt_r <= d_val;
    end
    if (cmd.advance) begin
      tcur_r <= nxt_r;
    end
    if (cmd.cmp && better) begin
      best_thr_r <= tcur_r;
      best_nxt_r <= nxt_r;
    end
    if (cmd.sweep_en || cmd.tot_en) begin
      rom_a_r <= NLOG_TAB[rom_a_addr];
      rom_b_r <= NLOG_TAB[rom_b_addr];
    end
    if (cmd.sweep_init) begin
      sum_l_r <= '0;
      sum_r_r <= '0;
    end else if (rom_sweep_r) begin
      sum_l_r <= sum_l_r + SUM_W'(rom_a_r);
      sum_r_r <= sum_r_r + SUM_W'(rom_b_r);
    end
    if (rom_tot_r) begin
      term_l_r <= term_l_nxt;
      term_r_r <= term_r_nxt;
    end
    if (cmd.out_load) begin
      out_ns_r  <= !have_r;
      out_ent_r <= have_r ? best_ent_r : ebss_pkg::ENT_MAX;
      for (int i = 0; i < ebss_pkg::OUT_THR_W; i++) begin
        out_thr_r[i] <= have_r && mid[(i < VALUE_BITS) ? i : VALUE_BITS - 1];
      end
    end
  end

  assign sts.spread    = spread_r;
  assign sts.mixed     = mixed_r;
  assign sts.nxt_found = nxt_found_r;
  assign cnt           = cnt_r;
  assign out_thr       = out_thr_r;
  assign out_ent       = out_ent_r;
  assign out_ns        = out_ns_r;

endmodule

// ----- hw/rtl/entropy_best_split_search_core.sv -----
// Top level of the entropy-based best split search block.
`timescale 1ns / 1ps

// The input channel carries one sample per transfer: a signed Q16.16 value, a class
// label and a last-sample flag. Samples are written into an on-chip sample memory at
// one per cycle; samples beyond MAX_SAMPLES are dropped, but a dropped last sample
// still starts evaluation. The transfer with last_sample set starts the evaluation,
// during which in_ready stays low. Evaluation first scans the column once to check
// value spread and class mix and build the right-side histogram. Then, for each
// distinct value d in ascending order, it scans the memory again and, if a larger
// value remains, sweeps the class histograms through the n*log2(n) table and scores
// the split. Each column yields exactly one result transfer on the output channel,
// holding the split threshold, the weighted entropy and the no-split flag. The result
// stays valid and unchanged while out_ready is low, and the block takes no new sample
// until that result transfer completes. Synchronous reset returns the block to loading
// with an empty sample memory.
module entropy_best_split_search_core #(
  parameter int MAX_SAMPLES = ebss_pkg::DEF_MAX_SAMPLES,
  parameter int NUM_CLASSES = ebss_pkg::DEF_NUM_CLASSES,
  parameter int VALUE_BITS  = ebss_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ebss_pkg::IN_VALUE_W-1:0] in_sample_value,
  input  logic [ebss_pkg::IN_CLASS_W-1:0] in_sample_class,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ebss_pkg::OUT_THR_W-1:0]  out_split_threshold,
  output logic [ebss_pkg::ENT_W-1:0]      out_weighted_entropy,
  output logic                            out_no_split
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CLS_W = $clog2(NUM_CLASSES);

  ebss_pkg::cmd_t   cmd;
  ebss_pkg::sts_t   sts;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    rd_addr;
  logic [CLS_W-1:0] cls_idx;

  // The controller walks the load, scan, sweep and score phases.
  ebss_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_sample),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cnt       (cnt),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .cls_idx   (cls_idx)
  );

  // The datapath holds the samples, histograms, sums and the best split so far.
  ebss_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .NUM_CLASSES (NUM_CLASSES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .cls_idx  (cls_idx),
    .in_value (in_sample_value),
    .in_class (in_sample_class),
    .sts      (sts),
    .cnt      (cnt),
    .out_thr  (out_split_threshold),
    .out_ent  (out_weighted_entropy),
    .out_ns   (out_no_split)
  );

endmodule
